>>> design/skte_pkg.sv
// Shared types and constants for the sorted key table engine.
// No dependencies; used by skte_ctrl, skte_dpath and the top level.
`default_nettype none

package skte_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned KeyBytesDef   = 8;
  localparam int unsigned KeyW          = 64;
  localparam int unsigned ValW          = 64;
  localparam int unsigned IdxOutW       = 6;
  localparam int unsigned CntOutW       = 7;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_UPDATE = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]      func;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IdxOutW-1:0] entry_index;
    logic [CntOutW-1:0] entries_now;
  } out_t;

  typedef enum logic [2:0] {
    PTR_HOLD  = 3'd0,
    PTR_CLEAR = 3'd1,
    PTR_INC   = 3'd2,
    PTR_DEC   = 3'd3,
    PTR_CNT   = 3'd4,
    PTR_POS   = 3'd5
  } ptr_op_e;

  typedef enum logic [1:0] {
    RD_PTR  = 2'd0,
    RD_PREV = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  typedef struct packed {
    logic    load;
    ptr_op_e ptr_op;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_at_pos;
    logic    wr_shift;
    logic    pos_set;
    logic    pos_hit;
    cnt_op_e cnt_op;
    logic    resp_load;
    status_e resp_status;
    logic    resp_use_pos;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  ptr_at_cnt;
    logic  key_ge;
    logic  key_eq;
    logic  match;
    logic  full;
    logic  ptr_gt_pos;
    logic  next_lt_cnt;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> design/skte_dpath.sv
// Datapath of the sorted key table engine: key/value memories, pointers,
// entry count and the output register. Depends on skte_pkg.
`default_nettype none

module skte_dpath #(
  parameter int unsigned TABLE_DEPTH = skte_pkg::TableDepthDef,
  parameter int unsigned KEY_BYTES   = skte_pkg::KeyBytesDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  skte_pkg::in_t       in_beat_i,
  input  skte_pkg::cmd_t      cmd_i,
  output skte_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output skte_pkg::out_t      out_beat_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [skte_pkg::KeyW-1:0] KeyMask =
    {skte_pkg::KeyW{1'b1}} << (skte_pkg::KeyW - 8 * KEY_BYTES);
  localparam logic [CntW-1:0] Depth = CntW'(TABLE_DEPTH);

  logic [skte_pkg::KeyW-1:0] key_mem [TABLE_DEPTH];
  logic [skte_pkg::ValW-1:0] val_mem [TABLE_DEPTH];

  logic [1:0]                func_q;
  logic [skte_pkg::KeyW-1:0] key_q, rd_key_q;
  logic [skte_pkg::ValW-1:0] val_q, rd_val_q;
  logic [CntW-1:0]           cnt_q, cnt_d, ptr_q, ptr_d, pos_q;
  logic                      match_q;
  logic                      out_valid_q;
  skte_pkg::out_t            out_q;

  logic [CntW-1:0]           rd_ptr;
  logic [IdxW-1:0]           rd_addr, wr_addr;
  logic [skte_pkg::KeyW-1:0] wr_key;
  logic [skte_pkg::ValW-1:0] wr_val;
  logic [CntW:0]             ptr_next;

  assign ptr_next = {1'b0, ptr_q} + {{CntW{1'b0}}, 1'b1};

  always_comb begin
    case (cmd_i.rd_sel)
      skte_pkg::RD_PREV: rd_ptr = ptr_q - {{(CntW-1){1'b0}}, 1'b1};
      skte_pkg::RD_NEXT: rd_ptr = ptr_next[CntW-1:0];
      default:           rd_ptr = ptr_q;
    endcase
  end

  assign rd_addr = rd_ptr[IdxW-1:0];
  assign wr_addr = cmd_i.wr_at_pos ? pos_q[IdxW-1:0] : ptr_q[IdxW-1:0];
  assign wr_key  = cmd_i.wr_shift ? rd_key_q : key_q;
  assign wr_val  = cmd_i.wr_shift ? rd_val_q : val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (cmd_i.rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_val_q <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_beat_i.func;
      key_q  <= in_beat_i.key & KeyMask;
      val_q  <= in_beat_i.value;
    end
    if (cmd_i.pos_set) begin
      pos_q <= ptr_q;
    end
  end

  always_comb begin
    case (cmd_i.ptr_op)
      skte_pkg::PTR_CLEAR: ptr_d = '0;
      skte_pkg::PTR_INC:   ptr_d = ptr_next[CntW-1:0];
      skte_pkg::PTR_DEC:   ptr_d = ptr_q - {{(CntW-1){1'b0}}, 1'b1};
      skte_pkg::PTR_CNT:   ptr_d = cnt_q;
      skte_pkg::PTR_POS:   ptr_d = pos_q;
      default:             ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      skte_pkg::CNT_INC: cnt_d = cnt_q + {{(CntW-1){1'b0}}, 1'b1};
      skte_pkg::CNT_DEC: cnt_d = cnt_q - {{(CntW-1){1'b0}}, 1'b1};
      default:           cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      if (cmd_i.pos_set) begin
        match_q <= cmd_i.pos_hit;
      end
      if (cmd_i.resp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      out_q.status      <= cmd_i.resp_status;
      out_q.entry_index <= cmd_i.resp_use_pos ? skte_pkg::IdxOutW'(pos_q) : '0;
      out_q.entries_now <= skte_pkg::CntOutW'(cnt_q);
    end
  end

  assign sts_o.func        = skte_pkg::func_e'(func_q);
  assign sts_o.ptr_at_cnt  = (ptr_q == cnt_q);
  assign sts_o.key_ge      = (rd_key_q >= key_q);
  assign sts_o.key_eq      = (rd_key_q == key_q);
  assign sts_o.match       = match_q;
  assign sts_o.full        = (cnt_q == Depth);
  assign sts_o.ptr_gt_pos  = (ptr_q > pos_q);
  assign sts_o.next_lt_cnt = (ptr_next < {1'b0, cnt_q});
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth)
    else $error("entry count above table depth");

  a_inc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_op == skte_pkg::CNT_INC |-> cnt_q < Depth)
    else $error("insert into full table");

  a_dec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_op == skte_pkg::CNT_DEC |-> cnt_q != '0 && match_q)
    else $error("delete without a matching entry");

  a_resp_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resp_load |-> !out_valid_q || !out_stall_i)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

>>> design/skte_ctrl.sv
// Controller of the sorted key table engine: one-hot sequencer for scan,
// shift and write steps. Depends on skte_pkg; drives skte_dpath commands.
`default_nettype none

module skte_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  skte_pkg::sts_t  sts_i,
  output skte_pkg::cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_SCAN_RD  = 10'b00_0000_0010,
    S_SCAN_CMP = 10'b00_0000_0100,
    S_DECIDE   = 10'b00_0000_1000,
    S_ISH_CHK  = 10'b00_0001_0000,
    S_ISH_WR   = 10'b00_0010_0000,
    S_WRITE    = 10'b00_0100_0000,
    S_DSH_CHK  = 10'b00_1000_0000,
    S_DSH_WR   = 10'b01_0000_0000,
    S_RESP     = 10'b10_0000_0000
  } state_e;

  state_e            state_q, state_d;
  skte_pkg::status_e code_q, code_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load   = 1'b1;
          cmd_o.ptr_op = skte_pkg::PTR_CLEAR;
          code_d       = skte_pkg::ST_DONE;
          state_d      = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts_i.ptr_at_cnt) begin
          cmd_o.pos_set = 1'b1;
          cmd_o.pos_hit = 1'b0;
          state_d       = S_DECIDE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = skte_pkg::RD_PTR;
          state_d      = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts_i.key_ge) begin
          cmd_o.pos_set = 1'b1;
          cmd_o.pos_hit = sts_i.key_eq;
          state_d       = S_DECIDE;
        end else begin
          cmd_o.ptr_op = skte_pkg::PTR_INC;
          state_d      = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        case (sts_i.func)
          skte_pkg::FUNC_INSERT: begin
            if (sts_i.match) begin
              code_d  = skte_pkg::ST_DUP;
              state_d = S_RESP;
            end else if (sts_i.full) begin
              code_d  = skte_pkg::ST_FULL;
              state_d = S_RESP;
            end else begin
              cmd_o.ptr_op = skte_pkg::PTR_CNT;
              state_d      = S_ISH_CHK;
            end
          end
          skte_pkg::FUNC_UPDATE: begin
            if (sts_i.match) begin
              state_d = S_WRITE;
            end else begin
              code_d  = skte_pkg::ST_MISSING;
              state_d = S_RESP;
            end
          end
          skte_pkg::FUNC_DELETE: begin
            if (sts_i.match) begin
              cmd_o.ptr_op = skte_pkg::PTR_POS;
              state_d      = S_DSH_CHK;
            end else begin
              code_d  = skte_pkg::ST_MISSING;
              state_d = S_RESP;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_ISH_CHK: begin
        if (sts_i.ptr_gt_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = skte_pkg::RD_PREV;
          state_d      = S_ISH_WR;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_ISH_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_op   = skte_pkg::PTR_DEC;
        state_d        = S_ISH_CHK;
      end
      S_WRITE: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_at_pos = 1'b1;
        if (sts_i.func == skte_pkg::FUNC_INSERT) begin
          cmd_o.cnt_op = skte_pkg::CNT_INC;
        end
        state_d = S_RESP;
      end
      S_DSH_CHK: begin
        if (sts_i.next_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = skte_pkg::RD_NEXT;
          state_d      = S_DSH_WR;
        end else begin
          cmd_o.cnt_op = skte_pkg::CNT_DEC;
          state_d      = S_RESP;
        end
      end
      S_DSH_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_op   = skte_pkg::PTR_INC;
        state_d        = S_DSH_CHK;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp_load    = 1'b1;
          cmd_o.resp_status  = code_q;
          cmd_o.resp_use_pos = (code_q == skte_pkg::ST_DONE) &&
                               (sts_i.func != skte_pkg::FUNC_NOP);
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= skte_pkg::ST_DONE;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  a_wr_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE && sts_i.func != skte_pkg::FUNC_INSERT |-> sts_i.match)
    else $error("update write without a matching entry");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_SCAN_RD)
    else $error("accepted beat did not start a scan");

  a_resp_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.resp_load |=> state_q == S_IDLE)
    else $error("sequencer did not return to idle after result");

endmodule

`default_nettype wire

>>> design/sorted_key_table_engine_unit.sv
// Top level of the sorted key table engine: joins skte_ctrl and skte_dpath.
// Depends on skte_pkg, skte_ctrl and skte_dpath.
//
//   channel  direction  handshake                  payload
//   in       to block   in_valid_i / in_stall_o    in_beat_i  (func, key, value)
//   out      from block out_valid_o / out_stall_i  out_beat_o (status, entry_index,
//                                                  entries_now)
//
// One beat at a time: a scan reads and compares entries in turn (S_SCAN_RD,
// S_SCAN_CMP) up to the sorted slot, then a shift moves entries one at a
// time through the key/value memories, each read and then written back
// (S_ISH_CHK/S_ISH_WR on insert, S_DSH_CHK/S_DSH_WR on delete).
// Reset clears the entry count and the sequencer; memory contents are kept.
// The result register lets the next beat be taken while a result is stalled.
`default_nettype none

module sorted_key_table_engine_unit #(
  parameter int unsigned TABLE_DEPTH = skte_pkg::TableDepthDef,
  parameter int unsigned KEY_BYTES   = skte_pkg::KeyBytesDef
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  skte_pkg::in_t   in_beat_i,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output skte_pkg::out_t  out_beat_o
);

  skte_pkg::cmd_t cmd;
  skte_pkg::sts_t sts;

  skte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  skte_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_sorted_key_table_engine_unit.sv
// Self-checking testbench for sorted_key_table_engine_unit: drives insert, update,
// delete and no-op beats with random gaps and output stalls and checks every result.
// Depends on skte_pkg and the sorted_key_table_engine_unit RTL.
`default_nettype none

module tb_sorted_key_table_engine_unit;

  localparam int TABLE_DEPTH  = skte_pkg::TableDepthDef;
  localparam int KEY_BYTES    = skte_pkg::KeyBytesDef;
  localparam logic [63:0] KEY_MASK = ~((64'd1 << (64 - 8 * KEY_BYTES)) - 64'd1);
  localparam int RANDOM_ITEMS = 1030;
  localparam int QUIET_TAIL   = 100;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 20;
  localparam int STALL_LIMIT  = 3000;

  class key_table_tracker;
    logic [63:0]    key_tab [TABLE_DEPTH];
    logic [63:0]    val_tab [TABLE_DEPTH];
    int             entries;
    skte_pkg::out_t pending[$];
    int unsigned    errors;
    int unsigned    checked;
    int unsigned    peak;
    int unsigned    status_hits [4];

    function new();
      entries = 0;
      errors  = 0;
      checked = 0;
      peak    = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function int last_match(logic [63:0] k);
      int hit;
      hit = -1;
      for (int i = 0; i < entries; i++) if (key_tab[i] == k) hit = i;
      return hit;
    endfunction

    // Applies one accepted request to the table copy and queues its result.
    function void note_request(skte_pkg::in_t b);
      skte_pkg::out_t    want;
      logic [63:0]       k;
      int                hit;
      int                slot;
      skte_pkg::status_e st;
      logic [5:0]        idx;
      k   = b.key & KEY_MASK;
      st  = skte_pkg::ST_DONE;
      idx = '0;
      hit = last_match(k);
      case (skte_pkg::func_e'(b.func))
        skte_pkg::FUNC_INSERT: begin
          if (hit >= 0) st = skte_pkg::ST_DUP;
          else if (entries >= TABLE_DEPTH) st = skte_pkg::ST_FULL;
          else begin
            slot = 0;
            while (slot < entries && key_tab[slot] < k) slot++;
            for (int i = entries; i > slot; i--) begin
              key_tab[i] = key_tab[i-1];
              val_tab[i] = val_tab[i-1];
            end
            key_tab[slot] = k;
            val_tab[slot] = b.value;
            entries++;
            idx = slot[5:0];
          end
        end
        skte_pkg::FUNC_UPDATE: begin
          if (hit < 0) st = skte_pkg::ST_MISSING;
          else begin
            val_tab[hit] = b.value;
            idx = hit[5:0];
          end
        end
        skte_pkg::FUNC_DELETE: begin
          if (hit < 0) st = skte_pkg::ST_MISSING;
          else begin
            for (int i = hit; i + 1 < entries; i++) begin
              key_tab[i] = key_tab[i+1];
              val_tab[i] = val_tab[i+1];
            end
            entries--;
            idx = hit[5:0];
          end
        end
        default: ;
      endcase
      want.status      = st;
      want.entry_index = idx;
      want.entries_now = entries[6:0];
      pending.push_back(want);
      status_hits[st]++;
      if (entries > peak) peak = entries;
    endfunction

    function void check_result(skte_pkg::out_t got);
      skte_pkg::out_t want;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result status %0d index %0d count %0d",
                       got.status, got.entry_index, got.entries_now));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.status !== want.status || got.entry_index !== want.entry_index ||
          got.entries_now !== want.entries_now)
        flag($sformatf("result %0d: expected status %0d index %0d count %0d, got %0d %0d %0d",
                       checked, want.status, want.entry_index, want.entries_now,
                       got.status, got.entry_index, got.entries_now));
    endfunction
  endclass

  logic           clk;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  skte_pkg::in_t  in_beat   = '0;
  logic           out_stall = 1'b0;
  logic           in_stall;
  logic           out_valid;
  skte_pkg::out_t out_beat;

  int in_gap_pct    = 20;
  int out_stall_pct = 20;
  int items_sent    = 0;

  key_table_tracker sb = new();

  sorted_key_table_engine_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BYTES  (KEY_BYTES)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_result(out_beat);
  end

  // Output stall bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [63:0] text_key(string s);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) k[63-8*i -: 8] = s[i];
    return k;
  endfunction

  function automatic logic [63:0] pick_key(int present_pct);
    logic [63:0] k;
    int          len;
    if (sb.entries != 0 && $urandom_range(0, 99) < present_pct)
      return sb.key_tab[$urandom_range(0, sb.entries - 1)];
    k = '0;
    case ($urandom_range(0, 2))
      0: k = {$urandom, $urandom};
      1: begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) k[63-8*i -: 8] = 8'($urandom_range(8'h20, 8'h7e));
      end
      default: begin
        if (sb.entries != 0) begin
          k = sb.key_tab[$urandom_range(0, sb.entries - 1)];
          k = $urandom_range(0, 1) ? k + 64'd1 : k - 64'd1;
        end else k = {$urandom, $urandom};
      end
    endcase
    return k;
  endfunction

  task automatic push_request(skte_pkg::func_e f, logic [63:0] k, logic [63:0] v);
    skte_pkg::in_t b;
    b.func  = f;
    b.key   = k;
    b.value = v;
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_request(b);
    items_sent++;
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    int              sent;
    int              mode;
    int              phase_len;
    int              r;
    int              ins_pct;
    int              upd_pct;
    int              del_pct;
    skte_pkg::func_e f;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, key extremes, duplicates, slot ends, no-op.
    push_request(skte_pkg::FUNC_UPDATE, text_key("NOBODY"), '1);
    push_request(skte_pkg::FUNC_DELETE, text_key("NOBODY"), '0);
    push_request(skte_pkg::FUNC_NOP, '1, '1);
    push_request(skte_pkg::FUNC_INSERT, '0, '1);
    push_request(skte_pkg::FUNC_INSERT, '1, '0);
    push_request(skte_pkg::FUNC_INSERT, text_key("MARIA"), 64'h0123_4567_89ab_cdef);
    push_request(skte_pkg::FUNC_INSERT, text_key("ADI"), 64'hfedc_ba98_7654_3210);
    push_request(skte_pkg::FUNC_INSERT, text_key("ZULKARNA"), 64'h1);
    push_request(skte_pkg::FUNC_INSERT, text_key("ADI"), 64'h2);
    push_request(skte_pkg::FUNC_INSERT, text_key("ADIT"), 64'h3);
    push_request(skte_pkg::FUNC_INSERT, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    push_request(skte_pkg::FUNC_UPDATE, '1, 64'ha5a5_a5a5_a5a5_a5a5);
    push_request(skte_pkg::FUNC_UPDATE, '0, 64'h5a5a_5a5a_5a5a_5a5a);
    push_request(skte_pkg::FUNC_UPDATE, text_key("MARIB"), 64'h4);
    push_request(skte_pkg::FUNC_NOP, '0, '0);
    push_request(skte_pkg::FUNC_DELETE, '0, '1);
    push_request(skte_pkg::FUNC_DELETE, '1, '1);
    push_request(skte_pkg::FUNC_DELETE, text_key("ADI"), '0);
    push_request(skte_pkg::FUNC_DELETE, text_key("ADI"), '0);
    push_request(skte_pkg::FUNC_INSERT, 64'h5555_5555_5555_5555, '1);
    push_request(skte_pkg::FUNC_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    push_request(skte_pkg::FUNC_UPDATE, text_key("ZULKARNA"), 64'haaaa_aaaa_aaaa_aaaa);
    wait_drained();

    sent = 0;
    mode = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 120);
      case ($urandom_range(0, 2))
        0: in_gap_pct = 0;
        1: in_gap_pct = 10;
        default: in_gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: out_stall_pct = 0;
        1: out_stall_pct = 10;
        default: out_stall_pct = 35;
      endcase
      case (mode)
        0: begin ins_pct = 80; upd_pct = 8;  del_pct = 6;  end
        1: begin ins_pct = 35; upd_pct = 30; del_pct = 30; end
        default: begin ins_pct = 15; upd_pct = 15; del_pct = 65; end
      endcase
      for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++) begin
        if (RANDOM_ITEMS - sent <= QUIET_TAIL) begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
        r = $urandom_range(0, 99);
        if (r < ins_pct) f = skte_pkg::FUNC_INSERT;
        else if (r < ins_pct + upd_pct) f = skte_pkg::FUNC_UPDATE;
        else if (r < ins_pct + upd_pct + del_pct) f = skte_pkg::FUNC_DELETE;
        else f = skte_pkg::FUNC_NOP;
        push_request(f, pick_key(f == skte_pkg::FUNC_INSERT ? 15 : 80),
                     {$urandom, $urandom});
        sent++;
      end
      r = $urandom_range(0, 9);
      mode = (r < 4) ? 0 : (r < 7) ? 1 : 2;
      if (RANDOM_ITEMS - sent > QUIET_TAIL && $urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.pending.size()));

    $display("Sent %0d requests, checked %0d results, table peaked at %0d entries",
             items_sent, sb.checked, sb.peak);
    $display("Outcomes: done %0d, duplicate %0d, missing %0d, full %0d; %0d mismatches",
             sb.status_hits[skte_pkg::ST_DONE], sb.status_hits[skte_pkg::ST_DUP],
             sb.status_hits[skte_pkg::ST_MISSING], sb.status_hits[skte_pkg::ST_FULL],
             sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
